[rtl/core/ceas_pkg.sv]
// ----------------------------------------------------------------------------
// ceas_pkg
// Types and constants shared by the CCD exposure averaging sequencer.
// ----------------------------------------------------------------------------
package ceas_pkg;

   // event kinds carried in the func field
   localparam logic [1:0] FUNC_HOST  = 2'd0;
   localparam logic [1:0] FUNC_ADC   = 2'd1;
   localparam logic [1:0] FUNC_ICG   = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   // data action codes
   localparam logic [2:0] ACTION_NONE      = 3'd0;
   localparam logic [2:0] ACTION_SEND      = 3'd1;
   localparam logic [2:0] ACTION_OVERWRITE = 3'd2;
   localparam logic [2:0] ACTION_ACCUM     = 3'd3;
   localparam logic [2:0] ACTION_AVERAGE   = 3'd4;

   localparam logic [7:0] KEY_FIRST     = 8'd69;
   localparam logic [7:0] KEY_SECOND    = 8'd82;
   localparam logic [7:0] MAX_AVERAGES  = 8'd15;
   localparam logic [5:0] PULSE_LIMIT   = 6'd32;
   localparam logic [5:0] RESTART_PULSE = 6'd6;
   localparam logic [5:0] FLUSH_PULSE   = 6'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] key_first;
      logic [7:0] key_second;
      logic [7:0] mode_request;
      logic [7:0] average_request;
   } req_type;

   typedef struct packed {
      logic [2:0] data_action;
      logic       adc_running;
      logic       flush_done;
      logic       exposure_change;
      logic [7:0] collect_mode;
      logic       led_level;
   } rsp_type;

   typedef struct packed {
      logic [5:0] pulse_count;
      logic [3:0] average_total;
      logic [3:0] exposures_remaining;
      logic [2:0] action_code;
      logic       adc_enable;
      logic       flushed_flag;
      logic [7:0] mode_store;
      logic       led_state;
   } state_type;

endpackage

[rtl/core/ceas_step.sv]
// ----------------------------------------------------------------------------
// ceas_step
// Next sequencer state and result for one event, applied to the current state.
// ----------------------------------------------------------------------------
module ceas_step (
   input  ceas_pkg::req_type   req,
   input  ceas_pkg::state_type state_cur,
   output ceas_pkg::state_type state_nxt,
   output ceas_pkg::rsp_type   rsp
);

   logic key_ok;
   logic avg_ok;
   logic change;

   assign key_ok = (req.key_first == ceas_pkg::KEY_FIRST) &&
                   (req.key_second == ceas_pkg::KEY_SECOND);
   assign avg_ok = (req.average_request != 8'd0) &&
                   (req.average_request <= ceas_pkg::MAX_AVERAGES);

   always_comb begin
      state_nxt = state_cur;
      change    = 1'b0;
      unique case (req.func)
         ceas_pkg::FUNC_HOST: begin
            if (key_ok) begin
               change                        = 1'b1;
               state_nxt.action_code         = ceas_pkg::ACTION_NONE;
               state_nxt.mode_store          = req.mode_request;
               state_nxt.average_total       = avg_ok ? req.average_request[3:0] : 4'd1;
               state_nxt.exposures_remaining = state_nxt.average_total;
            end
         end
         ceas_pkg::FUNC_ADC: begin
            state_nxt.adc_enable = 1'b0;
            if (state_cur.average_total == 4'd1) begin
               state_nxt.action_code = ceas_pkg::ACTION_SEND;
            end else if (state_cur.average_total > 4'd1) begin
               priority if (state_cur.exposures_remaining == state_cur.average_total) begin
                  state_nxt.pulse_count = ceas_pkg::RESTART_PULSE;
                  state_nxt.action_code = ceas_pkg::ACTION_OVERWRITE;
               end else if (state_cur.exposures_remaining < state_cur.average_total &&
                            state_cur.exposures_remaining > 4'd1) begin
                  state_nxt.pulse_count = ceas_pkg::RESTART_PULSE;
                  state_nxt.action_code = ceas_pkg::ACTION_ACCUM;
               end else if (state_cur.exposures_remaining == 4'd1) begin
                  state_nxt.action_code = ceas_pkg::ACTION_AVERAGE;
               end else begin
                  // remaining count out of step: keep the action
                  state_nxt.action_code = state_cur.action_code;
               end
               // saturate at zero
               if (state_cur.exposures_remaining != 4'd0) begin
                  state_nxt.exposures_remaining = state_cur.exposures_remaining - 4'd1;
               end
            end
         end
         ceas_pkg::FUNC_ICG: begin
            if (state_cur.pulse_count == ceas_pkg::RESTART_PULSE) begin
               state_nxt.adc_enable = 1'b1;
            end else if (state_cur.pulse_count == ceas_pkg::FLUSH_PULSE) begin
               state_nxt.flushed_flag = 1'b1;
            end
            if (state_cur.pulse_count >= ceas_pkg::PULSE_LIMIT) begin
               state_nxt.pulse_count = ceas_pkg::PULSE_LIMIT;
            end else begin
               state_nxt.pulse_count = state_cur.pulse_count + 6'd1;
            end
            state_nxt.led_state = ~state_cur.led_state;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.data_action     = state_nxt.action_code;
      rsp.adc_running     = state_nxt.adc_enable;
      rsp.flush_done      = state_nxt.flushed_flag;
      rsp.exposure_change = change;
      rsp.collect_mode    = state_nxt.mode_store;
      rsp.led_level       = state_nxt.led_state;
   end

endmodule

[rtl/core/ccd_exposure_averaging_sequencer.sv]
// Path: an event transferred in sits in the input register, is loaded into
// the result register when that register is free, and its result transfers
// from there. Throughput: one event per cycle when the result channel does
// not stall; the single-stage state update is the loop.
// Reset (synchronous, active high): pulse count 0, averaging and remaining
// counts 1, action, ADC, flushed, mode and LED all cleared; both stages empty.
// ----------------------------------------------------------------------------
// ccd_exposure_averaging_sequencer
// Event-driven exposure sequencer for a linear CCD with frame averaging.
// ----------------------------------------------------------------------------
module ccd_exposure_averaging_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ceas_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ceas_pkg::rsp_type rsp_data
);

   logic                in_valid_ff;
   logic                in_valid_in;
   ceas_pkg::req_type   in_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   ceas_pkg::rsp_type   rsp_data_ff;
   ceas_pkg::state_type state_ff;
   ceas_pkg::state_type state_in;
   ceas_pkg::rsp_type   step_rsp;
   logic                advance;
   logic                req_xfer;

   // move the held event into the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   ceas_step u_step (
      .req       (in_data_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
         state_ff.pulse_count         <= 6'd0;
         state_ff.average_total       <= 4'd1;
         state_ff.exposures_remaining <= 4'd1;
         state_ff.action_code         <= ceas_pkg::ACTION_NONE;
         state_ff.adc_enable          <= 1'b0;
         state_ff.flushed_flag        <= 1'b0;
         state_ff.mode_store          <= 8'd0;
         state_ff.led_state           <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_pulse_ceiling: assert property (@(posedge clock) disable iff (reset)
      state_ff.pulse_count <= ceas_pkg::PULSE_LIMIT)
      else $error("pulse count above ceiling");

   a_average_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.average_total != 4'd0 && state_ff.average_total <= 4'd15)
      else $error("averaging count out of range");

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.exposures_remaining <= state_ff.average_total)
      else $error("remaining count above averaging count");

   a_change_clears_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.exposure_change |->
         rsp_data_ff.data_action == ceas_pkg::ACTION_NONE)
      else $error("accepted command left a data action");

   a_state_moves_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an event");
`endif

endmodule

[tb/ccd_exposure_averaging_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// ccd_exposure_averaging_sequencer_checker
// Watches both channels of the exposure sequencer and tracks its event state.
// Every accepted event queues the status it should produce, and every accepted
// status is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ccd_exposure_averaging_sequencer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ceas_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ceas_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);

   ceas_pkg::state_type seq_state;
   ceas_pkg::rsp_type   expected_status_q[$];

   function automatic void clear_sequencer();
      seq_state                     = '0;
      seq_state.average_total       = 4'd1;
      seq_state.exposures_remaining = 4'd1;
   endfunction

   // Apply one event to the tracked state and return the status it reports.
   function automatic ceas_pkg::rsp_type advance_sequencer(input ceas_pkg::req_type ev);
      ceas_pkg::rsp_type status;
      logic              accepted;
      accepted = 1'b0;
      case (ev.func)
         ceas_pkg::FUNC_HOST: begin
            if (ev.key_first == ceas_pkg::KEY_FIRST &&
                ev.key_second == ceas_pkg::KEY_SECOND) begin
               accepted              = 1'b1;
               seq_state.action_code = ceas_pkg::ACTION_NONE;
               seq_state.mode_store  = ev.mode_request;
               if (ev.average_request != 8'd0 &&
                   ev.average_request <= ceas_pkg::MAX_AVERAGES)
                  seq_state.average_total = ev.average_request[3:0];
               else
                  seq_state.average_total = 4'd1;
               seq_state.exposures_remaining = seq_state.average_total;
            end
         end
         ceas_pkg::FUNC_ADC: begin
            seq_state.adc_enable = 1'b0;
            if (seq_state.average_total == 4'd1) begin
               seq_state.action_code = ceas_pkg::ACTION_SEND;
            end else if (seq_state.average_total > 4'd1) begin
               if (seq_state.exposures_remaining == seq_state.average_total) begin
                  seq_state.pulse_count = ceas_pkg::RESTART_PULSE;
                  seq_state.action_code = ceas_pkg::ACTION_OVERWRITE;
               end else if (seq_state.exposures_remaining < seq_state.average_total &&
                            seq_state.exposures_remaining > 4'd1) begin
                  seq_state.pulse_count = ceas_pkg::RESTART_PULSE;
                  seq_state.action_code = ceas_pkg::ACTION_ACCUM;
               end else if (seq_state.exposures_remaining == 4'd1) begin
                  seq_state.action_code = ceas_pkg::ACTION_AVERAGE;
               end
               // hold at zero once the run is used up
               if (seq_state.exposures_remaining != 4'd0)
                  seq_state.exposures_remaining = seq_state.exposures_remaining - 4'd1;
            end
         end
         ceas_pkg::FUNC_ICG: begin
            if (seq_state.pulse_count == ceas_pkg::RESTART_PULSE)
               seq_state.adc_enable = 1'b1;
            else if (seq_state.pulse_count == ceas_pkg::FLUSH_PULSE)
               seq_state.flushed_flag = 1'b1;
            if (seq_state.pulse_count < ceas_pkg::PULSE_LIMIT)
               seq_state.pulse_count = seq_state.pulse_count + 6'd1;
            seq_state.led_state = ~seq_state.led_state;
         end
         default: ;
      endcase
      status.data_action     = seq_state.action_code;
      status.adc_running     = seq_state.adc_enable;
      status.flush_done      = seq_state.flushed_flag;
      status.exposure_change = accepted;
      status.collect_mode    = seq_state.mode_store;
      status.led_level       = seq_state.led_state;
      return status;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      ceas_pkg::rsp_type want;
      if (reset) begin
         clear_sequencer();
         expected_status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               $error("status transfer with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("data_action", 32'(want.data_action),
                           32'(rsp_data.data_action));
               check_field("adc_running", 32'(want.adc_running),
                           32'(rsp_data.adc_running));
               check_field("flush_done", 32'(want.flush_done),
                           32'(rsp_data.flush_done));
               check_field("exposure_change", 32'(want.exposure_change),
                           32'(rsp_data.exposure_change));
               check_field("collect_mode", 32'(want.collect_mode),
                           32'(rsp_data.collect_mode));
               check_field("led_level", 32'(want.led_level),
                           32'(rsp_data.led_level));
            end
         end
         if (req_valid && req_ready)
            expected_status_q.push_back(advance_sequencer(req_data));
      end
      pending = expected_status_q.size();
   end

endmodule

[tb/ccd_exposure_averaging_sequencer_test.sv]
// ----------------------------------------------------------------------------
// ccd_exposure_averaging_sequencer_test
// Drives directed and random exposure events into the sequencer with random
// gaps on both channels; the checker predicts and compares every status.
// ----------------------------------------------------------------------------
module ccd_exposure_averaging_sequencer_test;

   localparam int RANDOM_EVENTS = 1750;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ceas_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ceas_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int events_sent = 0;
   int stall_left  = 0;
   bit no_idle     = 1'b0;

   ccd_exposure_averaging_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ccd_exposure_averaging_sequencer_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("ccd_exposure_averaging_sequencer test failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int roll;
      if (no_idle)
         return 0;
      roll = int'($urandom_range(0, 99));
      if (roll < 60)
         return 0;
      if (roll < 92)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_gap();
      end
   end

   function automatic ceas_pkg::req_type make_event(input logic [1:0] kind);
      ceas_pkg::req_type ev;
      ev.key_first       = 8'($urandom_range(0, 255));
      ev.key_second      = 8'($urandom_range(0, 255));
      ev.mode_request    = 8'($urandom_range(0, 255));
      ev.average_request = 8'($urandom_range(0, 255));
      ev.func            = kind;
      return ev;
   endfunction

   function automatic ceas_pkg::req_type make_command(input logic [7:0] mode,
                                                      input logic [7:0] count);
      ceas_pkg::req_type ev;
      ev                 = make_event(ceas_pkg::FUNC_HOST);
      ev.key_first       = ceas_pkg::KEY_FIRST;
      ev.key_second      = ceas_pkg::KEY_SECOND;
      ev.mode_request    = mode;
      ev.average_request = count;
      return ev;
   endfunction

   // Hold valid low for a random gap, then present the event until its transfer.
   task automatic send_event(input ceas_pkg::req_type ev);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
      events_sent++;
   endtask

   task automatic drain_status();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   task automatic send_pulses(input int count);
      repeat (count) send_event(make_event(ceas_pkg::FUNC_ICG));
   endtask

   // Command followed by pulse trains and readouts, up to two more than the count.
   task automatic exposure_run();
      logic [7:0] count;
      int         total;
      int         train;
      if ($urandom_range(0, 99) < 85)
         count = 8'($urandom_range(1, 15));
      else
         count = 8'($urandom_range(0, 255));
      send_event(make_command(8'($urandom_range(0, 255)), count));
      total = (count >= 8'd1 && count <= ceas_pkg::MAX_AVERAGES) ? int'(count) : 1;
      repeat (total + int'($urandom_range(0, 2))) begin
         if ($urandom_range(0, 19) == 0)
            train = int'($urandom_range(26, 40));
         else
            train = int'($urandom_range(1, 8));
         send_pulses(train);
         send_event(make_event(ceas_pkg::FUNC_ADC));
      end
   endtask

   task automatic noise_run();
      ceas_pkg::req_type ev;
      repeat ($urandom_range(3, 12)) begin
         ev = make_event(2'($urandom_range(0, 3)));
         if (ev.func == ceas_pkg::FUNC_HOST && $urandom_range(0, 1) == 1) begin
            ev.key_first  = ceas_pkg::KEY_FIRST;
            ev.key_second = ceas_pkg::KEY_SECOND;
         end
         send_event(ev);
      end
   endtask

   // Readouts out of step with the pulses, mostly readouts.
   task automatic broken_run();
      send_event(make_command(8'($urandom_range(0, 255)), 8'($urandom_range(2, 15))));
      repeat ($urandom_range(2, 8))
         send_event(make_event($urandom_range(0, 3) == 0 ? ceas_pkg::FUNC_ICG :
                                                          ceas_pkg::FUNC_ADC));
   endtask

   initial begin
      ceas_pkg::req_type ev;
      int                pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      send_event(make_event(ceas_pkg::FUNC_SPARE));
      ev = make_command(8'h11, 8'd4);
      ev.key_first = ceas_pkg::KEY_FIRST - 8'd1;
      send_event(ev);
      ev = make_command(8'h22, 8'd4);
      ev.key_second = ceas_pkg::KEY_SECOND + 8'd1;
      send_event(ev);
      send_event(make_command(8'hFF, 8'd0));
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_event(make_command(8'h00, 8'd16));
      send_event(make_command(8'hA5, 8'd255));
      send_event(make_command(8'h5A, ceas_pkg::MAX_AVERAGES));
      send_pulses(4);
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_pulses(1);
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_event(make_command(8'h01, 8'd2));
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_event(make_event(ceas_pkg::FUNC_ADC));
      send_pulses(1);
      send_event(make_event(ceas_pkg::FUNC_SPARE));
      send_event(make_command(8'h80, 8'd1));
      drain_status();

      // random part
      events_sent = 0;
      while (events_sent < RANDOM_EVENTS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         pick = int'($urandom_range(0, 9));
         if (pick < 7)
            exposure_run();
         else if (pick < 9)
            noise_run();
         else
            broken_run();
         if ($urandom_range(0, 19) == 0)
            drain_status();
      end
      no_idle = 1'b0;

      drain_status();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ccd_exposure_averaging_sequencer test passed");
      else
         $display("ccd_exposure_averaging_sequencer test failed");
      $finish;
   end

endmodule

[ccd_exposure_averaging_sequencer.f]
rtl/core/ceas_pkg.sv
rtl/core/ceas_step.sv
rtl/core/ccd_exposure_averaging_sequencer.sv
tb/ccd_exposure_averaging_sequencer_checker.sv
tb/ccd_exposure_averaging_sequencer_test.sv
